FILE: src/tcdf_pkg.sv
// ----------------------------------------------------------------------------
// tcdf_pkg
// Shared constants for the tabulated cdf energy sampler: item modes, field
// widths and the default table depth.
// ----------------------------------------------------------------------------
package tcdf_pkg;

    localparam int BINS_MAX_DEF = 256;

    localparam int WEIGHT_W = 32;
    localparam int EDGE_W   = 32;
    localparam int RAND_W   = 32;
    localparam int CUM_W    = 40;
    localparam int BIN_W    = 8;
    localparam int MODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

endpackage

FILE: src/tabulated_cdf_energy_sampler.sv
// ----------------------------------------------------------------------------
// tabulated_cdf_energy_sampler
// Histogram inverse-transform sampler: appends bins to a cumulative weight
// table in memory and draws energies by walking that table.
// ----------------------------------------------------------------------------
// clear and append items complete in the cycle they are taken; a sample with no loaded weight
// skips the walk and returns the error flag. Any other sample scales its pick by the total,
// walks the cumulative table one entry a cycle, then reads both edges of the chosen bin;
// the next item is taken in the cycle after the result is loaded, and a result that still
// waits in the output register holds back only the next sample's result, not its start.
// synchronous active-low reset clears bin count, total and handshakes, not the tables.
module tabulated_cdf_energy_sampler #(
    parameter int BINS_MAX = tcdf_pkg::BINS_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bin_weight[31:0], bin_lower_edge[63:32], pick_random[95:64],
    // spread_random[127:96]
    input  logic [127:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // chosen_bin[7:0], sampled_energy[39:8]
    output logic [39:0]  m_axis_tdata,
    // zero_width_bin[0], no_weight_error[1]
    output logic [1:0]   m_axis_tuser
);

    localparam int AW = $clog2(BINS_MAX);
    localparam int CW = $clog2(BINS_MAX + 1);
    localparam int CUM_W  = tcdf_pkg::CUM_W;
    localparam int EDGE_W = tcdf_pkg::EDGE_W;
    localparam int RAND_W = tcdf_pkg::RAND_W;
    localparam int BIN_W  = tcdf_pkg::BIN_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE_MUL,
        S_SCALE_ADD,
        S_WALK,
        S_EDGE_LO,
        S_EDGE_HI,
        S_EDGE_CMP,
        S_SPREAD_MUL,
        S_FINISH,
        S_DONE
    } t_state;

    t_state r_state;

    // table memories
    logic [CUM_W-1:0]  r_cum_mem  [BINS_MAX];
    logic [EDGE_W-1:0] r_edge_mem [BINS_MAX];
    logic [CUM_W-1:0]  r_cum_rdata;
    logic [EDGE_W-1:0] r_edge_rdata;
    logic [AW-1:0]     n_edge_raddr;
    logic              n_wr_en;

    logic [CW-1:0]     r_loaded;
    logic [CUM_W-1:0]  r_total;

    // per-sample working registers
    logic [RAND_W-1:0] r_pick;
    logic [RAND_W-1:0] r_spread;
    logic [63:0]       r_prod;
    logic [39:0]       r_prod_hi;
    logic [CUM_W-1:0]  r_target;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_prev;
    logic              r_rd_vld;
    logic [AW-1:0]     r_chosen;
    logic [EDGE_W-1:0] r_lo;
    logic [EDGE_W-1:0] r_diff;
    logic              r_up;
    logic              r_flat;
    logic              r_last;

    logic [BIN_W-1:0]  r_res_bin;
    logic [EDGE_W-1:0] r_res_energy;
    logic              r_res_zw;
    logic              r_res_err;

    logic              r_out_valid;
    logic [39:0]       r_out_data;
    logic [1:0]        r_out_user;

    logic [1:0]        in_mode;
    logic [31:0]       in_weight;
    logic [31:0]       in_edge;
    logic              in_fire;
    logic [CUM_W:0]    n_sum;
    logic [CUM_W-1:0]  n_sum_sat;
    logic [63:0]       n_mul;
    logic [RAND_W-1:0] n_mul_a;
    logic [31:0]       n_mul_b;
    logic              n_hit;
    logic [CW-1:0]     n_next_cnt;
    logic [EDGE_W-1:0] n_energy;

    assign in_mode   = s_axis_tuser;
    assign in_weight = s_axis_tdata[31:0];
    assign in_edge   = s_axis_tdata[63:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // appends land only while idle, read data is used only during a sample: no overlap
    assign n_wr_en   = in_fire && (in_mode == tcdf_pkg::MODE_APPEND)
                       && (r_loaded != CW'(BINS_MAX));
    assign n_sum     = {1'b0, r_total} + (CUM_W + 1)'(in_weight);
    assign n_sum_sat = n_sum[CUM_W] ? {CUM_W{1'b1}} : n_sum[CUM_W-1:0];

    // shared 32x32 multiplier: scaling by the low word of total, then spread by width
    assign n_mul_a = (r_state == S_SCALE_MUL) ? r_pick : r_spread;
    assign n_mul_b = (r_state == S_SCALE_MUL) ? r_total[31:0] : r_diff;
    assign n_mul   = 64'(n_mul_a) * 64'(n_mul_b);

    assign n_edge_raddr = (r_state == S_EDGE_LO) ? r_chosen : r_chosen + AW'(1);

    assign n_hit = r_rd_vld && ((r_cum_rdata > r_target)
                   || (CW'(r_prev) == r_loaded - CW'(1)));

    assign n_next_cnt = CW'(r_chosen) + CW'(1);

    always_comb begin
        if (r_last || r_flat) begin
            n_energy = r_lo;
        end else if (r_up) begin
            n_energy = r_lo + r_prod[63:32];
        end else begin
            n_energy = r_lo - r_prod[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_cum_mem[r_loaded[AW-1:0]] <= n_sum_sat;
        end
        r_cum_rdata <= r_cum_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_edge_mem[r_loaded[AW-1:0]] <= in_edge;
        end
        r_edge_rdata <= r_edge_mem[n_edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            // in S_DONE the output register is handled below
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_pick   <= s_axis_tdata[95:64];
                        r_spread <= s_axis_tdata[127:96];
                        case (in_mode)
                            tcdf_pkg::MODE_CLEAR: begin
                                r_loaded <= '0;
                                r_total  <= '0;
                            end
                            tcdf_pkg::MODE_APPEND: begin
                                if (n_wr_en) begin
                                    r_total  <= n_sum_sat;
                                    r_loaded <= r_loaded + CW'(1);
                                end
                            end
                            tcdf_pkg::MODE_SAMPLE: begin
                                if (r_loaded == '0 || r_total == '0) begin
                                    r_res_bin    <= '0;
                                    r_res_energy <= '0;
                                    r_res_zw     <= 1'b0;
                                    r_res_err    <= 1'b1;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_SCALE_MUL;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCALE_MUL: begin
                    r_prod    <= n_mul;
                    r_prod_hi <= 40'(r_pick) * 40'(r_total[CUM_W-1:32]);
                    r_state   <= S_SCALE_ADD;
                end
                S_SCALE_ADD: begin
                    r_target <= r_prod_hi + CUM_W'(r_prod[63:32]);
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_state  <= S_WALK;
                end
                S_WALK: begin
                    // address r_idx goes out, data for r_prev comes back
                    if (n_hit) begin
                        r_chosen <= r_prev;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_EDGE_LO;
                    end else begin
                        r_prev   <= r_idx;
                        r_idx    <= r_idx + AW'(1);
                        r_rd_vld <= 1'b1;
                    end
                end
                S_EDGE_LO: begin
                    r_state <= S_EDGE_HI;
                end
                S_EDGE_HI: begin
                    r_lo    <= r_edge_rdata;
                    r_last  <= (n_next_cnt >= r_loaded);
                    r_state <= S_EDGE_CMP;
                end
                S_EDGE_CMP: begin
                    // next edge arrives; a wrapped address for the last bin is not used
                    r_up    <= (r_edge_rdata > r_lo);
                    r_flat  <= (r_edge_rdata == r_lo);
                    r_diff  <= (r_edge_rdata > r_lo) ? r_edge_rdata - r_lo
                                                     : r_lo - r_edge_rdata;
                    r_state <= S_SPREAD_MUL;
                end
                S_SPREAD_MUL: begin
                    r_prod  <= n_mul;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_res_bin    <= BIN_W'(r_chosen);
                    r_res_energy <= n_energy;
                    r_res_zw     <= r_last || r_flat;
                    r_res_err    <= 1'b0;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_res_energy, r_res_bin};
                        r_out_user  <= {r_res_err, r_res_zw};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
